### rtl/kwm_pkg.sv
// Shared definitions for the k-way merge heap block: default parameter values,
// fixed stream field widths and the heap memory control bundle.
// No dependencies.
`default_nettype none

package kwm_pkg;

  // Default sizes of the block.
  localparam int NUM_LISTS_DEF   = 8;
  localparam int LIST_DEPTH_DEF  = 8;
  localparam int VALUE_WIDTH_DEF = 32;

  // Fixed widths of the stream fields.
  localparam int ID_W   = 3;
  localparam int DATA_W = 32;

  // Control bundle from the sequencer to the heap memory.
  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } heap_ctl_t;

endpackage

`default_nettype wire

### rtl/kwm_heap_ram.sv
// Heap entry memory: one write port and two registered read ports.
// Depends on kwm_pkg for the control bundle type.
`default_nettype none

module kwm_heap_ram #(
  parameter int DEPTH = kwm_pkg::NUM_LISTS_DEF,
  parameter int DW    = kwm_pkg::VALUE_WIDTH_DEF + $clog2(kwm_pkg::NUM_LISTS_DEF)
) (
  input  wire                         clk,
  input  wire kwm_pkg::heap_ctl_t     ctl,
  input  wire  [$clog2(DEPTH)-1:0]    rd_addr_a,
  input  wire  [$clog2(DEPTH)-1:0]    rd_addr_b,
  input  wire  [$clog2(DEPTH)-1:0]    wr_addr,
  input  wire  [DW-1:0]               wr_data,
  output logic [DW-1:0]               rd_data_a,
  output logic [DW-1:0]               rd_data_b
);

  logic [DW-1:0] heap_mem [DEPTH];

  // Reads return the old contents; the sequencer reads and writes the same entry
  // in the same cycle only for a child index past the heap, whose data is ignored.
  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      heap_mem[wr_addr] <= wr_data;
    end
    if (ctl.rd_en) begin
      rd_data_a <= heap_mem[rd_addr_a];
      rd_data_b <= heap_mem[rd_addr_b];
    end
  end

endmodule

`default_nettype wire

### rtl/k_way_merge_heap.sv
// k_way_merge_heap: top level; list element store, sequencer and output register.
// Depends on kwm_pkg and kwm_heap_ram.
// Elements load in S_IDLE. After the last one, S_SEED puts each list's head in the heap;
// heap building runs S_HFY_RD, S_HFY_LD and S_SIFT per node. A result that refills passes
// S_POP_RD, S_POP_TOP, S_POP_FILL and S_SIFT; one whose list is exhausted skips the fill.
// S_SIFT repeats per level descended, at most floor(log2(NUM_LISTS)); the final result
// ends in S_POP_TOP, an empty set in S_EMPTY. A stalled result stream holds the sequencer.
// Reset (rst_n low, synchronous) clears counts, heap size and the sequencer; stores stay.
`default_nettype none

module k_way_merge_heap #(
  parameter int NUM_LISTS   = kwm_pkg::NUM_LISTS_DEF,
  parameter int LIST_DEPTH  = kwm_pkg::LIST_DEPTH_DEF,
  parameter int VALUE_WIDTH = kwm_pkg::VALUE_WIDTH_DEF
) (
  input  wire                          clk,
  input  wire                          rst_n,
  // Input stream: one list element per transaction.
  input  wire                          in_tvalid,
  output logic                         in_tready,
  input  wire  [kwm_pkg::DATA_W-1:0]   in_tdata,   // [31:0] value
  input  wire  [kwm_pkg::ID_W-1:0]     in_tuser,   // [2:0] list_id
  input  wire                          in_tlast,   // last element of the data set
  // Result stream: merged ascending sequence.
  output logic                         out_tvalid,
  input  wire                          out_tready,
  output logic [kwm_pkg::DATA_W-1:0]   out_tdata,  // [31:0] value_res
  output logic                         out_tuser,  // [0] empty_res
  output logic                         out_tlast   // last_out
);

  localparam int NL  = NUM_LISTS;
  localparam int LD  = LIST_DEPTH;
  localparam int VW  = VALUE_WIDTH;
  localparam int LW  = $clog2(NL);        // list number width
  localparam int HW  = LW;                // heap index width
  localparam int HSW = $clog2(NL + 1);    // heap size width
  localparam int CW  = $clog2(LD + 1);    // per-list count width
  localparam int SD  = NL * LD;           // element store depth
  localparam int SW  = $clog2(SD);        // element store address width
  localparam int EW  = VW + LW;           // heap entry: {value, list}
  localparam int CXW = HW + 2;            // child index width
  // Flipping the value's sign bit turns the signed (value, list) ordering
  // into a plain unsigned compare of the whole entry.
  localparam logic [EW-1:0] SIGN_FLIP = {1'b1, {(EW-1){1'b0}}};

  // The sequencer is one-hot. Loading happens in S_IDLE only.
  typedef enum logic [8:0] {
    S_IDLE     = 9'b000000001,
    S_SEED     = 9'b000000010,
    S_HFY_RD   = 9'b000000100,
    S_HFY_LD   = 9'b000001000,
    S_SIFT     = 9'b000010000,
    S_POP_RD   = 9'b000100000,
    S_POP_TOP  = 9'b001000000,
    S_POP_FILL = 9'b010000000,
    S_EMPTY    = 9'b100000000
  } state_t;

  state_t          state_r, state_nxt;
  logic [CW-1:0]   count_r [NL];
  logic [CW-1:0]   count_nxt [NL];
  logic [CW-1:0]   rp_r [NL];
  logic [CW-1:0]   rp_nxt [NL];
  logic            any_r, any_nxt;
  logic [HSW-1:0]  hsz_r, hsz_nxt;
  logic [HSW-1:0]  seed_l_r, seed_l_nxt;
  logic            pend_r, pend_nxt;
  logic [LW-1:0]   pend_list_r, pend_list_nxt;
  logic [HW-1:0]   j_r, j_nxt;
  logic [HW-1:0]   i_r, i_nxt;
  logic            mode_pop_r, mode_pop_nxt;
  logic [LW-1:0]   fill_list_r, fill_list_nxt;
  logic [EW-1:0]   car_r, car_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic [kwm_pkg::DATA_W-1:0] out_value_r, out_value_nxt;
  logic            out_empty_r, out_empty_nxt;
  logic            out_last_r, out_last_nxt;
  logic            out_load;

  // Element store, one region of LIST_DEPTH entries per list.
  logic [VW-1:0]   store_mem [SD];
  logic [VW-1:0]   store_rd_r;
  logic            store_wr_en;
  logic [SW-1:0]   store_wr_addr;
  logic            store_rd_en;
  logic [SW-1:0]   store_rd_addr;

  // Heap memory port signals.
  kwm_pkg::heap_ctl_t heap_ctl;
  logic [HW-1:0]   ha_addr, hb_addr, hw_addr;
  logic [EW-1:0]   hw_data;
  logic [EW-1:0]   rda_r, rdb_r;
  logic            kids_rd;
  logic [HW-1:0]   kids_base;

  // Input decode.
  logic            accept;
  logic            id_ok;
  logic [LW-1:0]   in_idx;
  logic [VW-1:0]   in_val;
  logic [CW-1:0]   cnt_in;
  logic            room;

  // Seeding and popping helpers.
  logic [LW-1:0]   seed_idx;
  logic            seed_more;
  logic            seed_has;
  logic [HSW-1:0]  hsz_after;
  logic [LW-1:0]   top_list;
  logic signed [VW-1:0] top_val;
  logic            refill;
  logic            out_free;

  // Sift-down step on the hole at i_r with the carried entry car_r.
  logic [CXW-1:0]  cl, cr;
  logic            lv, rv;
  logic            pick_r;
  logic [EW-1:0]   best;
  logic [CXW-1:0]  best_idx;
  logic            go_down;

  assign accept  = in_tvalid && in_tready;
  assign id_ok   = 32'(in_tuser) < 32'(NL);
  assign in_idx  = LW'(in_tuser);
  assign in_val  = VW'(in_tdata);
  assign cnt_in  = count_r[in_idx];
  assign room    = cnt_in < CW'(LD);

  assign seed_idx  = seed_l_r[LW-1:0];
  assign seed_more = seed_l_r < HSW'(NL);
  assign seed_has  = count_r[seed_idx] != '0;
  assign hsz_after = hsz_r + HSW'(pend_r);

  assign top_list = rda_r[LW-1:0];
  assign top_val  = rda_r[EW-1:LW];
  assign refill   = rp_r[top_list] < count_r[top_list];
  assign out_free = !out_valid_r || out_tready;

  assign cl       = {1'b0, i_r, 1'b1};
  assign cr       = cl + CXW'(1);
  assign lv       = cl < CXW'(hsz_r);
  assign rv       = cr < CXW'(hsz_r);
  assign pick_r   = rv && ((rdb_r ^ SIGN_FLIP) < (rda_r ^ SIGN_FLIP));
  assign best     = pick_r ? rdb_r : rda_r;
  assign best_idx = pick_r ? cr : cl;
  assign go_down  = lv && ((best ^ SIGN_FLIP) < (car_r ^ SIGN_FLIP));

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    rp_nxt        = rp_r;
    any_nxt       = any_r;
    hsz_nxt       = hsz_r;
    seed_l_nxt    = seed_l_r;
    pend_nxt      = 1'b0;
    pend_list_nxt = pend_list_r;
    j_nxt         = j_r;
    i_nxt         = i_r;
    mode_pop_nxt  = mode_pop_r;
    fill_list_nxt = fill_list_r;
    car_nxt       = car_r;
    out_load      = 1'b0;
    out_value_nxt = out_value_r;
    out_empty_nxt = out_empty_r;
    out_last_nxt  = out_last_r;
    store_wr_en   = 1'b0;
    store_wr_addr = '0;
    store_rd_en   = 1'b0;
    store_rd_addr = '0;
    heap_ctl      = '0;
    ha_addr       = '0;
    hb_addr       = '0;
    hw_addr       = '0;
    hw_data       = '0;
    kids_rd       = 1'b0;
    kids_base     = '0;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          // Elements for an unknown list or a full list are dropped.
          if (id_ok && room) begin
            store_wr_en        = 1'b1;
            store_wr_addr      = SW'(32'(in_idx) * 32'(LD) + 32'(cnt_in));
            count_nxt[in_idx]  = cnt_in + CW'(1);
            any_nxt            = 1'b1;
          end
          if (in_tlast) begin
            if (any_nxt) begin
              state_nxt  = S_SEED;
              seed_l_nxt = '0;
              hsz_nxt    = '0;
            end else begin
              state_nxt = S_EMPTY;
            end
          end
        end
      end

      S_SEED: begin
        // The head read in the previous cycle is appended to the heap while
        // the next list's head is read.
        if (pend_r) begin
          heap_ctl.wr_en = 1'b1;
          hw_addr        = hsz_r[HW-1:0];
          hw_data        = {store_rd_r, pend_list_r};
        end
        hsz_nxt = hsz_after;
        if (seed_more) begin
          if (seed_has) begin
            store_rd_en      = 1'b1;
            store_rd_addr    = SW'(32'(seed_idx) * 32'(LD));
            rp_nxt[seed_idx] = CW'(1);
            pend_nxt         = 1'b1;
            pend_list_nxt    = seed_idx;
          end
          seed_l_nxt = seed_l_r + HSW'(1);
        end else if (hsz_after > HSW'(1)) begin
          j_nxt     = HW'((hsz_after >> 1) - HSW'(1));
          state_nxt = S_HFY_RD;
        end else begin
          state_nxt = S_POP_RD;
        end
      end

      S_HFY_RD: begin
        heap_ctl.rd_en = 1'b1;
        ha_addr        = j_r;
        state_nxt      = S_HFY_LD;
      end

      S_HFY_LD: begin
        car_nxt      = rda_r;
        i_nxt        = j_r;
        mode_pop_nxt = 1'b0;
        kids_rd      = 1'b1;
        kids_base    = j_r;
        state_nxt    = S_SIFT;
      end

      S_SIFT: begin
        heap_ctl.wr_en = 1'b1;
        hw_addr        = i_r;
        if (go_down) begin
          // The smaller child moves up into the hole; its children are read
          // in the same cycle for the next step.
          hw_data   = best;
          i_nxt     = best_idx[HW-1:0];
          kids_rd   = 1'b1;
          kids_base = best_idx[HW-1:0];
        end else begin
          hw_data = car_r;
          if (mode_pop_r || (j_r == '0)) begin
            state_nxt = S_POP_RD;
          end else begin
            j_nxt     = j_r - HW'(1);
            state_nxt = S_HFY_RD;
          end
        end
      end

      S_POP_RD: begin
        heap_ctl.rd_en = 1'b1;
        ha_addr        = '0;
        hb_addr        = HW'(hsz_r - HSW'(1));
        state_nxt      = S_POP_TOP;
      end

      S_POP_TOP: begin
        if (out_free) begin
          out_load      = 1'b1;
          out_value_nxt = kwm_pkg::DATA_W'(top_val);
          out_empty_nxt = 1'b0;
          out_last_nxt  = !refill && (hsz_r == HSW'(1));
          if (refill) begin
            store_rd_en      = 1'b1;
            store_rd_addr    = SW'(32'(top_list) * 32'(LD) + 32'(rp_r[top_list]));
            rp_nxt[top_list] = rp_r[top_list] + CW'(1);
            fill_list_nxt    = top_list;
            state_nxt        = S_POP_FILL;
          end else if (hsz_r == HSW'(1)) begin
            // Final result: clear the list bookkeeping for the next data set.
            count_nxt = '{default: '0};
            rp_nxt    = '{default: '0};
            any_nxt   = 1'b0;
            hsz_nxt   = '0;
            state_nxt = S_IDLE;
          end else begin
            // Popped list is exhausted: the last heap entry replaces the root.
            car_nxt      = rdb_r;
            hsz_nxt      = hsz_r - HSW'(1);
            i_nxt        = '0;
            mode_pop_nxt = 1'b1;
            kids_rd      = 1'b1;
            kids_base    = '0;
            state_nxt    = S_SIFT;
          end
        end
      end

      S_POP_FILL: begin
        car_nxt      = {store_rd_r, fill_list_r};
        i_nxt        = '0;
        mode_pop_nxt = 1'b1;
        kids_rd      = 1'b1;
        kids_base    = '0;
        state_nxt    = S_SIFT;
      end

      S_EMPTY: begin
        if (out_free) begin
          out_load      = 1'b1;
          out_value_nxt = '0;
          out_empty_nxt = 1'b1;
          out_last_nxt  = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // Children of kids_base; an index past the heap reads a don't-care
    // entry that the validity checks ignore.
    if (kids_rd) begin
      heap_ctl.rd_en = 1'b1;
      ha_addr        = HW'({kids_base, 1'b1});
      hb_addr        = HW'({1'b0, kids_base, 1'b1} + CXW'(1));
    end
  end

  assign out_valid_nxt = out_load ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '{default: '0};
      rp_r        <= '{default: '0};
      any_r       <= 1'b0;
      hsz_r       <= '0;
      seed_l_r    <= '0;
      pend_r      <= 1'b0;
      j_r         <= '0;
      i_r         <= '0;
      mode_pop_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      rp_r        <= rp_nxt;
      any_r       <= any_nxt;
      hsz_r       <= hsz_nxt;
      seed_l_r    <= seed_l_nxt;
      pend_r      <= pend_nxt;
      j_r         <= j_nxt;
      i_r         <= i_nxt;
      mode_pop_r  <= mode_pop_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_list_r <= pend_list_nxt;
    fill_list_r <= fill_list_nxt;
    car_r       <= car_nxt;
    out_value_r <= out_value_nxt;
    out_empty_r <= out_empty_nxt;
    out_last_r  <= out_last_nxt;
  end

  // Element store: written while loading, read while seeding and refilling.
  always_ff @(posedge clk) begin
    if (store_wr_en) begin
      store_mem[store_wr_addr] <= in_val;
    end
    if (store_rd_en) begin
      store_rd_r <= store_mem[store_rd_addr];
    end
  end

  kwm_heap_ram #(
    .DEPTH (NL),
    .DW    (EW)
  ) u_heap_ram (
    .clk       (clk),
    .ctl       (heap_ctl),
    .rd_addr_a (ha_addr),
    .rd_addr_b (hb_addr),
    .wr_addr   (hw_addr),
    .wr_data   (hw_data),
    .rd_data_a (rda_r),
    .rd_data_b (rdb_r)
  );

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_value_r;
  assign out_tuser  = out_empty_r;
  assign out_tlast  = out_last_r;

endmodule

`default_nettype wire

### rtl/kwm_checker.sv
// Port-level checker for k_way_merge_heap and the bind that attaches it.
// Depends on kwm_pkg for field widths.
`default_nettype none

module kwm_checker (
  input wire                        clk,
  input wire                        rst_n,
  input wire                        in_tvalid,
  input wire                        in_tready,
  input wire                        in_tlast,
  input wire                        out_tvalid,
  input wire                        out_tready,
  input wire [kwm_pkg::DATA_W-1:0]  out_tdata,
  input wire                        out_tuser,
  input wire                        out_tlast
);

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result withdrawn while stalled");

  // A stalled result keeps its payload.
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tlast)
      && $stable(out_tuser))
    else $error("result payload changed while stalled");

  // The empty marker is a single zero result that closes the sequence.
  a_empty_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tlast && (out_tdata == '0))
    else $error("empty result malformed");

  // The merge starts right after the last element: loading stops.
  a_merge_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tlast |=> !in_tready)
    else $error("input still accepted after last element");

endmodule

bind k_way_merge_heap kwm_checker u_kwm_checker (.*);

`default_nettype wire

### dv/tb_k_way_merge_heap.sv
// Self-checking testbench for k_way_merge_heap: directed and random list sets
// are merged by a behavioral predictor and compared with the result stream.
// Depends on kwm_pkg and the k_way_merge_heap RTL.
`default_nettype none

module tb_k_way_merge_heap;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DATA_W       = kwm_pkg::DATA_W;
  localparam int ID_W         = kwm_pkg::ID_W;
  localparam int LISTS        = kwm_pkg::NUM_LISTS_DEF;
  localparam int DEPTH        = kwm_pkg::LIST_DEPTH_DEF;
  localparam int RESET_CYCLES = 10;
  // Slack after the last expected result: a full seeding and heap build fits well inside.
  localparam int DRAIN_CYCLES = 60;
  localparam int MAX_REPORTS  = 10;
  localparam int ITEMS_PER_PHASE = 80;

  localparam logic [DATA_W-1:0] VAL_MIN = 32'h8000_0000;
  localparam logic [DATA_W-1:0] VAL_MAX = 32'h7FFF_FFFF;

  // One expected transaction on the result stream.
  typedef struct {
    logic [DATA_W-1:0] value;
    logic              empty;
    logic              last;
  } merged_result_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_tvalid = 1'b0;
  logic              in_tready;
  logic [DATA_W-1:0] in_tdata = '0;   // [31:0] value
  logic [ID_W-1:0]   in_tuser = '0;   // [2:0] list_id
  logic              in_tlast = 1'b0; // last element of the data set
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [DATA_W-1:0] out_tdata;       // [31:0] value_res
  logic              out_tuser;       // [0] empty_res
  logic              out_tlast;       // last_out

  k_way_merge_heap dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor state: a copy of the list stores as the block should hold them.
  logic [DATA_W-1:0] list_vals [LISTS][DEPTH];
  int                list_len  [LISTS];

  // Merged values still owed by the block, oldest first.
  merged_result_t merged_expected[$];

  // Idle controls for the current phase, in percent.
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;

  int mismatches     = 0;
  int items_sent     = 0;
  int sets_sent      = 0;
  int results_seen   = 0;

  // The receiver stalls at random. Only one assignment per falling edge.
  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Signed ordering of two stored values, with the lower list winning a tie.
  function automatic bit head_precedes(logic [DATA_W-1:0] a, int la,
                                       logic [DATA_W-1:0] b, int lb);
    if ($signed(a) != $signed(b))
      return $signed(a) < $signed(b);
    return la < lb;
  endfunction

  // Store one accepted element; on the last one, produce the whole merged sequence.
  // The heap always holds exactly one head per unfinished list, so each pop is the
  // smallest current head, which a scan over the heads reproduces directly.
  task automatic absorb_element(input int id, input logic [DATA_W-1:0] val,
                                input bit is_last);
    int             rd_ptr[LISTS];
    int             total;
    int             best;
    int             remaining;
    merged_result_t r;
    if (id < LISTS && list_len[id] < DEPTH) begin
      list_vals[id][list_len[id]] = val;
      list_len[id]++;
    end
    if (!is_last)
      return;
    total = 0;
    for (int l = 0; l < LISTS; l++) begin
      rd_ptr[l] = 0;
      total += list_len[l];
    end
    if (total == 0) begin
      // Nothing was loaded: a single flagged transaction with a zero value.
      r.value = '0;
      r.empty = 1'b1;
      r.last  = 1'b1;
      merged_expected.insert(merged_expected.size(), r);
    end else begin
      remaining = total;
      while (remaining > 0) begin
        best = -1;
        for (int l = 0; l < LISTS; l++) begin
          if (rd_ptr[l] < list_len[l]) begin
            if (best < 0 || head_precedes(list_vals[l][rd_ptr[l]], l,
                                          list_vals[best][rd_ptr[best]], best))
              best = l;
          end
        end
        r.value = list_vals[best][rd_ptr[best]];
        r.empty = 1'b0;
        rd_ptr[best]++;
        remaining--;
        r.last = (remaining == 0);
        merged_expected.insert(merged_expected.size(), r);
      end
    end
    for (int l = 0; l < LISTS; l++)
      list_len[l] = 0;
    sets_sent++;
  endtask

  // Drive one element and wait for its transaction. Inputs change on the falling
  // edge; tvalid stays high after acceptance so back-to-back elements need no toggle.
  task automatic send_element(input int id, input logic [DATA_W-1:0] val,
                              input bit is_last);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      in_tdata  <= $urandom();
      in_tuser  <= ID_W'($urandom());
      in_tlast  <= 1'($urandom());
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= val;
    in_tuser  <= id[ID_W-1:0];
    in_tlast  <= is_last;
    @(posedge clk);
    while (!in_tready)
      @(posedge clk);
    items_sent++;
    absorb_element(id, val, is_last);
  endtask

  // Stop sending, then wait for every owed result and a little slack on top.
  task automatic wait_results_drained();
    @(negedge clk);
    in_tvalid <= 1'b0;
    in_tlast  <= 1'b0;
    while (merged_expected.size() > 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // A data set of one element must still come out as one last-marked result.
  task automatic test_single_element();
    send_element(LISTS - 1, VAL_MAX, 1'b1);
    send_element(0, VAL_MIN, 1'b1);
    wait_results_drained();
  endtask

  // Extreme values and ties across all lists; the tie order must follow list number.
  task automatic test_extremes_and_ties();
    send_element(3, VAL_MIN, 1'b0);
    for (int l = LISTS - 1; l >= 0; l--)
      send_element(l, '0, 1'b0);
    send_element(4, VAL_MAX, 1'b0);
    send_element(5, 32'hFFFF_FFFF, 1'b1);
    wait_results_drained();
  endtask

  // One list past its depth: the extra elements, the last one included, are dropped,
  // but the last flag still starts the merge.
  task automatic test_list_overflow();
    for (int i = 0; i < DEPTH + 2; i++)
      send_element(6, 32'(i * 3 - 7), i == DEPTH + 1);
    wait_results_drained();
  endtask

  // Build one random data set and send it with the lists interleaved at random.
  // Sorted lists are the normal case; unsorted ones exercise the merge on bad input.
  task automatic send_random_set(input int n_elems, input bit sorted_lists,
                                 input bit narrow_range, input bit crowd_one_list);
    int                pending[LISTS][$];
    int                hot;
    int                l;
    int                remaining;
    logic [DATA_W-1:0] v;
    hot = $urandom_range(LISTS - 1);
    for (int i = 0; i < n_elems; i++) begin
      l = (crowd_one_list && $urandom_range(1)) ? hot : $urandom_range(LISTS - 1);
      if (narrow_range)
        v = 32'($urandom_range(15)) - 32'd8;
      else if ($urandom_range(15) == 0)
        v = $urandom_range(1) ? VAL_MIN : VAL_MAX;
      else
        v = $urandom();
      pending[l].insert(pending[l].size(), int'(v));
    end
    if (sorted_lists)
      for (int k = 0; k < LISTS; k++)
        pending[k].sort();
    remaining = n_elems;
    while (remaining > 0) begin
      l = $urandom_range(LISTS - 1);
      if (pending[l].size() > 0) begin
        v = pending[l].pop_front();
        remaining--;
        send_element(l, v, remaining == 0);
      end
    end
  endtask

  // Random sets under one idling pattern. Most sets are small and well formed;
  // the rest crowd one list, break the sort order or run large.
  task automatic test_random_phase(input int send_pct, input int stall_pct);
    int start_items;
    int kind;
    start_items    = items_sent;
    send_idle_pct  = send_pct;
    recv_stall_pct = stall_pct;
    while (items_sent - start_items < ITEMS_PER_PHASE) begin
      kind = $urandom_range(99);
      if (kind < 10)
        send_random_set($urandom_range(DEPTH + 1, DEPTH + 6), 1'b1, 1'b0, 1'b1);
      else if (kind < 25)
        send_random_set($urandom_range(2, 12), 1'b0, $urandom_range(1), 1'b0);
      else if (kind < 37)
        send_random_set($urandom_range(2, 16), 1'b1, 1'b1, 1'b0);
      else if (kind < 42)
        send_random_set($urandom_range(40, LISTS * DEPTH), 1'b1, 1'b0, 1'b0);
      else
        send_random_set($urandom_range(1, 12), 1'b1, 1'b0, 1'b0);
    end
    wait_results_drained();
  endtask

  // Every result transaction is checked against the oldest owed value.
  always @(posedge clk) begin : check_results
    merged_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      if (merged_expected.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected result: value=%h empty=%b last=%b",
                   out_tdata, out_tuser, out_tlast);
      end else begin
        want = merged_expected.pop_front();
        if (out_tdata !== want.value || out_tuser !== want.empty ||
            out_tlast !== want.last) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("result mismatch: expected value=%h empty=%b last=%b,",
                     want.value, want.empty, want.last,
                     " got value=%h empty=%b last=%b",
                     out_tdata, out_tuser, out_tlast);
        end
      end
    end
  end

  initial begin
    for (int l = 0; l < LISTS; l++)
      list_len[l] = 0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_single_element();
    test_extremes_and_ties();
    test_list_overflow();
    test_random_phase(0, 0);
    test_random_phase(83, 0);
    test_random_phase(0, 83);
    test_random_phase(29, 29);

    $display("covered %0d elements in %0d merge sets, %0d merged results checked",
             items_sent, sets_sent, results_seen);
    $display("idle patterns: none, sender 83%%, receiver 83%%, both 29%%");
    if (mismatches == 0 && merged_expected.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("%0d mismatches, %0d results never arrived", mismatches,
               merged_expected.size());
      $display("tb: failure");
    end
    $finish;
  end

  // Watchdog: far longer than the slowest legal run of this stimulus.
  initial begin
    #5_000_000;
    $display("timeout with %0d results still owed", merged_expected.size());
    $display("tb: failure");
    $finish;
  end

endmodule

`default_nettype wire

### filelist.f
rtl/kwm_pkg.sv
rtl/kwm_heap_ram.sv
rtl/k_way_merge_heap.sv
rtl/kwm_checker.sv
dv/tb_k_way_merge_heap.sv
